FILE: sv/wsst_pkg.sv
package wsst_pkg;

	localparam int DEF_SLOTS = 16;
	localparam int CMD_W     = 3;
	localparam int IDX_W     = 4;
	localparam int ERR_W     = 2;
	localparam int USE_W     = 5;

	typedef enum logic [CMD_W-1:0] {
		CMD_ALLOC   = 3'd0,
		CMD_RELEASE = 3'd1,
		CMD_SET     = 3'd2,
		CMD_QUERY   = 3'd3,
		CMD_CLEAR   = 3'd4
	} cmd_e_t;

	typedef enum logic [1:0] {
		ST_FREE      = 2'd0,
		ST_NOT_READY = 2'd1,
		ST_READY     = 2'd2
	} slot_st_t;

	typedef enum logic [ERR_W-1:0] {
		ERR_NONE = 2'd0,
		ERR_FULL = 2'd1,
		ERR_FREE = 2'd2
	} err_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_OUT
	} fsm_t;

	typedef struct packed {
		logic             wr;
		logic [CMD_W-1:0] cmd;
	} cell_ctl_t;

	typedef struct packed {
		logic     claim;
		logic     full;
		slot_st_t addr_st;
	} scan_st_t;

endpackage

FILE: sv/wait_slot_status_table.sv
// Wait slot table of SLOTS slots, each free, not-ready or ready, held in a row
// of cells. One command word in gives one result word out; a new command is
// taken only after the previous result has been taken. Release, set-ready,
// reset-to-not-ready and query results are registered at acceptance and shown
// in the cycle after it. Allocate passes a search token down the row, one cell
// per cycle; the lowest free slot claims it, and a full table reports ERR_FULL.
module wait_slot_status_table #(
	parameter int SLOTS = wsst_pkg::DEF_SLOTS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // cmd[2:0], slot_index[6:3], zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // granted_slot[3:0], ok[4], is_ready[5],
	                               // error_code[7:6], in_use[12:8], zero pad
);
	import wsst_pkg::*;

	logic [CMD_W-1:0] cmd;
	logic [IDX_W-1:0] slot_index;
	logic             in_range;
	cell_ctl_t        ctl;
	scan_st_t         st;
	logic [SLOTS:0]   tok;
	logic [SLOTS-1:0] claim;
	logic [1:0]       addr_st [SLOTS];
	logic [1:0]       addr_or;
	logic [IDX_W-1:0] granted_slot;
	logic             ok, is_ready;
	logic [ERR_W-1:0] error_code;
	logic [USE_W-1:0] in_use;

	assign cmd        = s_tdata[2:0];
	assign slot_index = s_tdata[6:3];
	assign in_range   = (32'(slot_index) < SLOTS);

	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		wsst_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.sel     (32'(slot_index) == i),
			.tok_in  (tok[i]),
			.tok_out (tok[i+1]),
			.claim   (claim[i]),
			.addr_st (addr_st[i])
		);
	end

	always_comb begin
		addr_or = '0;
		for (int i = 0; i < SLOTS; i++) addr_or = addr_or | addr_st[i];
		st.claim   = |claim;
		st.full    = tok[SLOTS];
		st.addr_st = slot_st_t'(addr_or);
	end

	wsst_ctrl #(.SLOTS(SLOTS)) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_valid      (s_tvalid),
		.s_ready      (s_tready),
		.cmd          (cmd),
		.in_range     (in_range),
		.st           (st),
		.ctl          (ctl),
		.start        (tok[0]),
		.m_valid      (m_tvalid),
		.m_ready      (m_tready),
		.granted_slot (granted_slot),
		.ok           (ok),
		.is_ready     (is_ready),
		.error_code   (error_code),
		.in_use       (in_use)
	);

	assign m_tdata = {3'b000, in_use, error_code, is_ready, ok, granted_slot};

endmodule

FILE: sv/wsst_cell.sv
module wsst_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  wsst_pkg::cell_ctl_t ctl,
	input  logic                sel,
	input  logic                tok_in,
	output logic                tok_out,
	output logic                claim,
	output logic [1:0]          addr_st
);
	import wsst_pkg::*;

	slot_st_t st_q;
	logic     tok_q;

	assign claim   = tok_in && (st_q == ST_FREE);
	assign tok_out = tok_q;
	assign addr_st = sel ? st_q : ST_FREE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= ST_FREE;
			tok_q <= 1'b0;
		end else begin
			tok_q <= tok_in && !claim;
			if (claim) begin
				st_q <= ST_NOT_READY;
			end else if (ctl.wr && sel) begin
				case (ctl.cmd)
					CMD_RELEASE: st_q <= ST_FREE;
					CMD_SET: begin
						if (st_q != ST_FREE) st_q <= ST_READY;
					end
					CMD_CLEAR: begin
						if (st_q != ST_FREE) st_q <= ST_NOT_READY;
					end
					default: st_q <= st_q;
				endcase
			end
		end
	end

endmodule

FILE: sv/wsst_ctrl.sv
module wsst_ctrl #(
	parameter int SLOTS = wsst_pkg::DEF_SLOTS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_valid,
	output logic                        s_ready,
	input  logic [wsst_pkg::CMD_W-1:0]  cmd,
	input  logic                        in_range,
	input  wsst_pkg::scan_st_t          st,
	output wsst_pkg::cell_ctl_t         ctl,
	output logic                        start,
	output logic                        m_valid,
	input  logic                        m_ready,
	output logic [wsst_pkg::IDX_W-1:0]  granted_slot,
	output logic                        ok,
	output logic                        is_ready,
	output logic [wsst_pkg::ERR_W-1:0]  error_code,
	output logic [wsst_pkg::USE_W-1:0]  in_use
);
	import wsst_pkg::*;

	localparam int PW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);

	fsm_t            state_q, state_d;
	logic [PW-1:0]   pos_q;
	logic [CW-1:0]   count_q;
	logic            start_q;
	logic [IDX_W-1:0] granted_q;
	logic            ok_q, ready_q;
	err_t            err_q;
	logic            accept;

	assign accept = s_valid && s_ready;
	assign start  = start_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (s_valid) state_d = (cmd == CMD_ALLOC) ? S_SCAN : S_OUT;
			end
			S_SCAN: begin
				if (st.claim || st.full) state_d = S_OUT;
			end
			S_OUT: begin
				if (m_ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		s_ready    = (state_q == S_IDLE);
		m_valid    = (state_q == S_OUT);
		ctl.wr     = accept;
		ctl.cmd    = cmd;
		granted_slot = granted_q;
		ok         = ok_q;
		is_ready   = ready_q;
		error_code = err_q;
		in_use     = (count_q > CW'(31)) ? USE_W'(31) : USE_W'(count_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			start_q <= 1'b0;
			pos_q   <= '0;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			start_q <= accept && (cmd == CMD_ALLOC);
			if (accept) begin
				pos_q <= '0;
			end else if (state_q == S_SCAN) begin
				pos_q <= pos_q + PW'(1);
			end
			if (state_q == S_SCAN && st.claim) begin
				count_q <= count_q + CW'(1);
			end else if (accept && cmd == CMD_RELEASE && in_range
					&& st.addr_st != ST_FREE && count_q != '0) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			granted_q <= '0;
			ok_q      <= 1'b0;
			ready_q   <= 1'b0;
			err_q     <= ERR_NONE;
			case (cmd)
				CMD_RELEASE: begin
					if (in_range) ok_q <= 1'b1;
					else err_q <= ERR_FREE;
				end
				CMD_SET, CMD_CLEAR: begin
					if (in_range && st.addr_st != ST_FREE) ok_q <= 1'b1;
					else err_q <= ERR_FREE;
				end
				CMD_QUERY: begin
					if (in_range) begin
						ok_q    <= 1'b1;
						ready_q <= (st.addr_st == ST_READY);
					end else begin
						err_q <= ERR_FREE;
					end
				end
				default: ok_q <= 1'b0;
			endcase
		end else if (state_q == S_SCAN) begin
			if (st.claim) begin
				granted_q <= IDX_W'(pos_q);
				ok_q      <= 1'b1;
			end else if (st.full) begin
				err_q <= ERR_FULL;
			end
		end
	end

endmodule

FILE: test/tb_top.sv
module tb_top;
	import wsst_pkg::*;

	localparam int SLOTS       = DEF_SLOTS;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RAND_WORDS  = 1200;
	localparam int CALM_TAIL   = 150;

	localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd5;
	localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;

	typedef struct packed {
		logic [USE_W-1:0] in_use;
		err_t             err;
		logic             ready;
		logic             ok;
		logic [IDX_W-1:0] slot;
	} result_t;

	typedef struct {
		logic [CMD_W-1:0] cmd;
		logic [IDX_W-1:0] idx;
		bit               typed;
		result_t          want;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;

	slot_st_t    slot_state [SLOTS];
	int          taken_slots;
	result_t     pending_results [$];
	stim_row_t   directed_rows [$];
	int          errors;
	int          cycles;
	bit          calm;

	wait_slot_status_table #(
		.SLOTS(SLOTS)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic result_t word_of(logic [IDX_W-1:0] slot, logic ok, logic rdy,
			err_t err, logic [USE_W-1:0] used);
		result_t r;
		r.slot   = slot;
		r.ok     = ok;
		r.ready  = rdy;
		r.err    = err;
		r.in_use = used;
		return r;
	endfunction

	function automatic result_t slot_table_step(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] idx);
		result_t r;
		bit      in_range;
		bit      found;
		r        = '0;
		r.err    = ERR_NONE;
		in_range = int'(idx) < SLOTS;
		found    = 1'b0;
		case (cmd)
			CMD_ALLOC: begin
				r.err = ERR_FULL;
				for (int i = 0; i < SLOTS; i++) begin
					if (!found && slot_state[i] == ST_FREE) begin
						found         = 1'b1;
						slot_state[i] = ST_NOT_READY;
						taken_slots++;
						r.slot = i[IDX_W-1:0];
						r.ok   = 1'b1;
						r.err  = ERR_NONE;
					end
				end
			end
			CMD_RELEASE: begin
				if (!in_range) begin
					r.err = ERR_FREE;
				end else begin
					if (slot_state[idx] != ST_FREE && taken_slots > 0)
						taken_slots--;
					slot_state[idx] = ST_FREE;
					r.ok = 1'b1;
				end
			end
			CMD_SET, CMD_CLEAR: begin
				if (!in_range || slot_state[idx] == ST_FREE) begin
					r.err = ERR_FREE;
				end else begin
					slot_state[idx] = (cmd == CMD_SET) ? ST_READY : ST_NOT_READY;
					r.ok = 1'b1;
				end
			end
			CMD_QUERY: begin
				if (!in_range) begin
					r.err = ERR_FREE;
				end else begin
					r.ready = slot_state[idx] == ST_READY;
					r.ok    = 1'b1;
				end
			end
			default: ;
		endcase
		r.in_use = (taken_slots > 31) ? 5'd31 : taken_slots[USE_W-1:0];
		return r;
	endfunction

	task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
			input bit typed, input result_t want);
		result_t model;
		if (!calm && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {1'b0, idx, cmd};
		do @(posedge clk); while (!s_tready);
		model = slot_table_step(cmd, idx);
		pending_results.push_back(typed ? want : model);
		@(negedge clk);
	endtask

	task automatic check_word(input result_t want, input logic [15:0] data);
		result_t got;
		got = result_t'(data[12:0]);
		if (got.slot !== want.slot) begin
			$display("%0t granted_slot: expected %0d, got %0d", $time, want.slot, got.slot);
			errors++;
		end
		if (got.ok !== want.ok) begin
			$display("%0t ok: expected %0d, got %0d", $time, want.ok, got.ok);
			errors++;
		end
		if (got.ready !== want.ready) begin
			$display("%0t is_ready: expected %0d, got %0d", $time, want.ready, got.ready);
			errors++;
		end
		if (got.err !== want.err) begin
			$display("%0t error_code: expected %0d, got %0d", $time, want.err, got.err);
			errors++;
		end
		if (got.in_use !== want.in_use) begin
			$display("%0t in_use: expected %0d, got %0d", $time, want.in_use, got.in_use);
			errors++;
		end
		if (data[15:13] !== 3'b000) begin
			$display("%0t pad: expected 0, got %b", $time, data[15:13]);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$display("%0t unexpected word: expected none, got %h", $time, m_tdata);
				errors++;
			end else begin
				check_word(pending_results.pop_front(), m_tdata);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(negedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	initial begin
		logic [CMD_W-1:0] cmd;
		logic [IDX_W-1:0] idx;
		int               roll;
		int               alloc_cut;
		int               release_cut;
		int               phase_left;
		bit               filling;
		int               live [$];

		errors      = 0;
		cycles      = 0;
		calm        = 1'b0;
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		taken_slots = 0;
		foreach (slot_state[i])
			slot_state[i] = ST_FREE;

		directed_rows.push_back('{CMD_QUERY, 4'd0, 1'b1,
			word_of(4'd0, 1'b1, 1'b0, ERR_NONE, 5'd0)});
		directed_rows.push_back('{CMD_RELEASE, 4'd15, 1'b1,
			word_of(4'd0, 1'b1, 1'b0, ERR_NONE, 5'd0)});
		directed_rows.push_back('{CMD_SET, 4'd3, 1'b1,
			word_of(4'd0, 1'b0, 1'b0, ERR_FREE, 5'd0)});
		directed_rows.push_back('{CMD_CLEAR, 4'd3, 1'b1,
			word_of(4'd0, 1'b0, 1'b0, ERR_FREE, 5'd0)});
		directed_rows.push_back('{CMD_UNUSED_LO, 4'd0, 1'b1,
			word_of(4'd0, 1'b0, 1'b0, ERR_NONE, 5'd0)});
		directed_rows.push_back('{CMD_UNUSED_HI, 4'd15, 1'b1,
			word_of(4'd0, 1'b0, 1'b0, ERR_NONE, 5'd0)});
		directed_rows.push_back('{CMD_ALLOC, 4'd0, 1'b1,
			word_of(4'd0, 1'b1, 1'b0, ERR_NONE, 5'd1)});
		for (int i = 1; i < SLOTS - 1; i++)
			directed_rows.push_back('{CMD_ALLOC, 4'd0, 1'b0, '0});
		directed_rows.push_back('{CMD_ALLOC, 4'd0, 1'b1,
			word_of(4'd15, 1'b1, 1'b0, ERR_NONE, 5'd16)});
		directed_rows.push_back('{CMD_ALLOC, 4'd9, 1'b1,
			word_of(4'd0, 1'b0, 1'b0, ERR_FULL, 5'd16)});
		directed_rows.push_back('{CMD_SET, 4'd15, 1'b0, '0});
		directed_rows.push_back('{CMD_QUERY, 4'd15, 1'b1,
			word_of(4'd0, 1'b1, 1'b1, ERR_NONE, 5'd16)});
		directed_rows.push_back('{CMD_RELEASE, 4'd15, 1'b1,
			word_of(4'd0, 1'b1, 1'b0, ERR_NONE, 5'd15)});
		directed_rows.push_back('{CMD_ALLOC, 4'd0, 1'b0, '0});

		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i])
			send_word(directed_rows[i].cmd, directed_rows[i].idx, directed_rows[i].typed,
				directed_rows[i].want);

		filling    = 1'b0;
		phase_left = 0;
		for (int n = 0; n < RAND_WORDS; n++) begin
			calm = (n % 250) < 40 || n >= RAND_WORDS - CALM_TAIL;
			if (phase_left == 0) begin
				filling    = !filling;
				phase_left = $urandom_range(30, 80);
			end
			phase_left--;
			alloc_cut   = filling ? 50 : 20;
			release_cut = filling ? 60 : 50;
			roll        = $urandom_range(0, 99);
			if (roll < 4)
				cmd = CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
			else if (roll < alloc_cut)
				cmd = CMD_ALLOC;
			else if (roll < release_cut)
				cmd = CMD_RELEASE;
			else if (roll < release_cut + (100 - release_cut) / 3)
				cmd = CMD_SET;
			else if (roll < release_cut + 2 * (100 - release_cut) / 3)
				cmd = CMD_QUERY;
			else
				cmd = CMD_CLEAR;
			live.delete();
			foreach (slot_state[i])
				if (slot_state[i] != ST_FREE)
					live.push_back(i);
			if (live.size() > 0 && $urandom_range(0, 3) != 0)
				idx = IDX_W'(live[$urandom_range(0, live.size() - 1)]);
			else
				idx = IDX_W'($urandom_range(0, 15));
			send_word(cmd, idx, 1'b0, '0);
		end
		s_tvalid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SLOTS + 8) @(posedge clk);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

FILE: wait_slot_status_table.f
sv/wsst_pkg.sv
sv/wsst_cell.sv
sv/wsst_ctrl.sv
sv/wait_slot_status_table.sv
test/tb_top.sv
